// File: rtl/core/adaptive_cyclic_phase_estimator_assert.svh
// assertion macros shared by the phase estimator checkers
`ifndef ADAPTIVE_CYCLIC_PHASE_ESTIMATOR_ASSERT_SVH
`define ADAPTIVE_CYCLIC_PHASE_ESTIMATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define ACPE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acpe check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define ACPE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acpe check failed");

`endif

// File: rtl/core/acpe_pkg.sv
// shared types and constants of the adaptive cyclic phase estimator
package acpe_pkg;
	localparam int DEF_MAX_PHASES = 8;
	localparam int PHASE_W = 3;
	localparam int STAMP_W = 48;
	localparam int DUR_W = 16;
	localparam int ELAP_W = 32;
	localparam int PROG_W = 17;
	localparam int FRAC_W = 16;
	localparam int LR_W = 16;
	localparam int NP_W = 4;
	localparam int LR_SHIFT = 14;
	localparam int IN_TDATA_W = 72;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_NUM_PHASES = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_LEARN_RATE = 1'b1;
	localparam logic [NP_W-1:0] NUM_PHASES_RST = 4'd4;
	localparam logic [LR_W-1:0] LEARN_RATE_RST = 16'd1638;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_COPY,
		ST_OUT
	} acpe_state_t;

	// write enables into the duration store
	typedef struct packed {
		logic load_we;
		logic next_we;
		logic copy_we;
	} acpe_mem_ctl_t;
endpackage

// File: rtl/core/adaptive_cyclic_phase_estimator.sv
// top level of the adaptive cyclic phase estimator: sequencer and datapath
//
// One item at a time. A load or a backward timestamp goes straight to the output state after
// acceptance. A sample walks the duration store one entry a cycle to build the cycle total,
// the sum of earlier phases and the current duration, then, unless the progress is zero or
// saturates at one, a 16-step serial divider forms the Q1.16 progress, and an advancing
// sample adds a multiply and a write-back plus, when the cycle wraps, a copy of the next
// model into the current one at one entry a cycle. No clearing pass after reset: durations
// must be loaded before samples are sent.
module adaptive_cyclic_phase_estimator #(
	parameter int MAX_PHASES = acpe_pkg::DEF_MAX_PHASES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// timestamp_ms, advance_phase, load_index, load_duration_ms, zero fill
	input  logic [acpe_pkg::IN_TDATA_W-1:0]      s_tdata,
	// req_type
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// progress_q16, phase_now, phase_changed, time_error, zero fill
	output logic [acpe_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                 cfg_we,
	input  logic [acpe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [acpe_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import acpe_pkg::*;

	localparam int AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
	localparam int NU_W = $clog2(MAX_PHASES + 1);
	localparam int SW = DUR_W + NU_W;
	localparam int CW = (AW + 1 > NU_W) ? AW + 1 : NU_W;
	localparam int PROD_W = 50;

	acpe_state_t state_q, state_d;
	acpe_mem_ctl_t mem_ctl;

	// configuration
	logic [NP_W-1:0] np_q;
	logic [LR_W-1:0] lr_q;

	// architectural state
	logic [AW-1:0] phase_q;
	logic [ELAP_W-1:0] elap_q;
	logic [STAMP_W-1:0] last_stamp_q;
	logic first_q;

	// sequencer scratch
	logic issuing_q;
	logic vld_s1;
	logic [AW-1:0] idx_s1;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] last_q;
	logic adv_q;
	logic terr_q;
	logic [SW-1:0] total_q;
	logic [SW-1:0] before_q;
	logic [DUR_W-1:0] cur_q;
	logic [DUR_W-1:0] nxt_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [PROG_W-1:0] prog_q;
	logic m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// input fields
	logic [STAMP_W-1:0] in_stamp;
	logic in_adv;
	logic [PHASE_W-1:0] in_lidx;
	logic [DUR_W-1:0] in_ldur;
	logic [DUR_W-1:0] ldur_fix;
	logic lidx_ok;
	logic acc;

	logic [STAMP_W-1:0] prev_stamp;
	logic back;
	logic [STAMP_W:0] sum_el;
	logic [ELAP_W-1:0] elap_new;

	logic [NU_W-1:0] n_used;
	logic [AW-1:0] last_idx;
	logic [DUR_W-1:0] cur_min;
	logic [SW:0] num;
	logic prog_direct;
	logic wrap;
	logic [AW-1:0] phase_nx;
	logic issue;
	logic [AW-1:0] stop_idx;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [DUR_W-1:0] wr_data;
	logic [DUR_W-1:0] model_rd;
	logic [DUR_W-1:0] next_rd;
	logic div_start;
	logic div_done;
	logic [FRAC_W-1:0] div_quot;

	logic signed [PROD_W-1:0] err_ext;
	logic signed [PROD_W-1:0] lr_ext;
	logic signed [PROD_W-1:0] biased;
	logic signed [PROD_W-1:0] corr;
	logic signed [PROD_W-1:0] vsum;
	logic [DUR_W-1:0] upd_dur;

	assign in_stamp = s_tdata[STAMP_W-1:0];
	assign in_adv = s_tdata[STAMP_W];
	assign in_lidx = s_tdata[STAMP_W+PHASE_W:STAMP_W+1];
	assign in_ldur = s_tdata[STAMP_W+PHASE_W+DUR_W:STAMP_W+PHASE_W+1];
	assign ldur_fix = (in_ldur == '0) ? DUR_W'(1) : in_ldur;
	assign lidx_ok = 32'(in_lidx) < MAX_PHASES;

	assign s_tready = state_q == ST_IDLE;
	assign acc = s_tvalid && s_tready;

	// elapsed time from the previous sample, first sample counts as zero
	always_comb begin
		prev_stamp = first_q ? in_stamp : last_stamp_q;
		back = in_stamp < prev_stamp;
		sum_el = {{(STAMP_W + 1 - ELAP_W){1'b0}}, elap_q} + {1'b0, in_stamp - prev_stamp};
		elap_new = (|sum_el[STAMP_W:ELAP_W]) ? '1 : sum_el[ELAP_W-1:0];
	end

	always_comb begin
		if (np_q == '0) begin
			n_used = NU_W'(1);
		end else if (32'(np_q) > MAX_PHASES) begin
			n_used = NU_W'(MAX_PHASES);
		end else begin
			n_used = NU_W'(np_q);
		end
		last_idx = (CW'(phase_q) >= CW'(n_used) - CW'(1)) ? phase_q : AW'(n_used - 1'b1);
	end

	always_comb begin
		cur_min = (elap_q < {{(ELAP_W - DUR_W){1'b0}}, cur_q}) ? elap_q[DUR_W-1:0] : cur_q;
		num = {{(SW + 1 - DUR_W){1'b0}}, cur_min} + {1'b0, before_q};
		prog_direct = (total_q == '0) || (num >= {1'b0, total_q});
		wrap = CW'(phase_q) + CW'(1) >= CW'(n_used);
		phase_nx = wrap ? '0 : phase_q + 1'b1;
	end

	// correction of the next model: gain times error, truncated toward zero, clamped
	always_comb begin
		err_ext = $signed({{(PROD_W - ELAP_W){1'b0}}, elap_q})
			- $signed({{(PROD_W - DUR_W){1'b0}}, cur_q});
		lr_ext = $signed({{(PROD_W - LR_W){1'b0}}, lr_q});
		biased = prod_q[PROD_W-1] ? prod_q + PROD_W'((1 << LR_SHIFT) - 1) : prod_q;
		corr = biased >>> LR_SHIFT;
		vsum = $signed({{(PROD_W - DUR_W){1'b0}}, nxt_q}) + corr;
		if (vsum < $signed(PROD_W'(1))) begin
			upd_dur = DUR_W'(1);
		end else if (vsum > $signed(PROD_W'({DUR_W{1'b1}}))) begin
			upd_dur = '1;
		end else begin
			upd_dur = vsum[DUR_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (s_tuser == REQ_LOAD || back) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_SUM;
					end
				end
			end
			ST_SUM: begin
				if (vld_s1 && idx_s1 == last_q) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (!prog_direct) begin
					state_d = ST_DIV;
				end else begin
					state_d = adv_q ? ST_MUL : ST_OUT;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = adv_q ? ST_MUL : ST_OUT;
				end
			end
			ST_MUL: state_d = ST_UPD;
			ST_UPD: state_d = wrap ? ST_COPY : ST_OUT;
			ST_COPY: begin
				if (vld_s1 && idx_s1 == AW'(MAX_PHASES - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		issue = issuing_q && (state_q == ST_SUM || state_q == ST_COPY);
		stop_idx = (state_q == ST_COPY) ? AW'(MAX_PHASES - 1) : last_q;
		rd_addr = cnt_q;
		mem_ctl.load_we = acc && s_tuser == REQ_LOAD && lidx_ok;
		mem_ctl.next_we = state_q == ST_UPD;
		mem_ctl.copy_we = state_q == ST_COPY && vld_s1;
		div_start = state_q == ST_PREP && !prog_direct;
		case (state_q)
			ST_UPD: begin
				wr_addr = phase_q;
				wr_data = upd_dur;
			end
			ST_COPY: begin
				wr_addr = idx_s1;
				wr_data = next_rd;
			end
			default: begin
				wr_addr = AW'(in_lidx);
				wr_data = ldur_fix;
			end
		endcase
	end

	acpe_mem #(
		.MAX_PHASES(MAX_PHASES),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.ctl(mem_ctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.model_rd(model_rd),
		.next_rd(next_rd)
	);

	acpe_div #(
		.W(SW + 1)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num),
		.den(total_q),
		.done(div_done),
		.quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			np_q <= NUM_PHASES_RST;
			lr_q <= LEARN_RATE_RST;
			phase_q <= '0;
			elap_q <= '0;
			last_stamp_q <= '0;
			first_q <= 1'b1;
			issuing_q <= 1'b0;
			vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_NUM_PHASES: np_q <= cfg_wdata[NP_W-1:0];
					REG_LEARN_RATE: lr_q <= cfg_wdata[LR_W-1:0];
					default: ;
				endcase
			end
			vld_s1 <= issue;
			if (issue && cnt_q == stop_idx) begin
				issuing_q <= 1'b0;
			end
			if (acc) begin
				if (s_tuser == REQ_LOAD) begin
					phase_q <= '0;
					elap_q <= '0;
					first_q <= 1'b1;
				end else if (!back) begin
					elap_q <= elap_new;
					last_stamp_q <= in_stamp;
					first_q <= 1'b0;
					issuing_q <= 1'b1;
				end
			end
			if (state_q == ST_UPD) begin
				elap_q <= '0;
				phase_q <= phase_nx;
				issuing_q <= wrap;
			end
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (issue) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (acc) begin
			cnt_q <= '0;
			last_q <= last_idx;
			adv_q <= s_tuser == REQ_SAMPLE && in_adv && !back;
			terr_q <= s_tuser == REQ_SAMPLE && back;
			total_q <= '0;
			before_q <= '0;
			prog_q <= '0;
		end
		if (state_q == ST_SUM && vld_s1) begin
			if (CW'(idx_s1) < CW'(n_used)) begin
				total_q <= total_q + {{(SW - DUR_W){1'b0}}, model_rd};
			end
			if (idx_s1 < phase_q) begin
				before_q <= before_q + {{(SW - DUR_W){1'b0}}, model_rd};
			end
			if (idx_s1 == phase_q) begin
				cur_q <= model_rd;
				nxt_q <= next_rd;
			end
		end
		if (state_q == ST_PREP && prog_direct) begin
			// at or past the full cycle the fraction saturates at one
			prog_q <= (total_q == '0) ? '0 : PROG_W'(1 << FRAC_W);
		end
		if (state_q == ST_DIV && div_done) begin
			prog_q <= {1'b0, div_quot};
		end
		if (state_q == ST_MUL) begin
			prod_q <= err_ext * lr_ext;
		end
		if (state_q == ST_UPD) begin
			cnt_q <= '0;
		end
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= OUT_TDATA_W'({terr_q, adv_q, PHASE_W'(phase_q), prog_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
endmodule

// File: rtl/core/acpe_mem.sv
// current and next duration models, one registered read port each
module acpe_mem #(
	parameter int MAX_PHASES = acpe_pkg::DEF_MAX_PHASES,
	parameter int AW = 3
) (
	input  logic                      clk,
	input  acpe_pkg::acpe_mem_ctl_t   ctl,
	input  logic [AW-1:0]             rd_addr,
	input  logic [AW-1:0]             wr_addr,
	input  logic [acpe_pkg::DUR_W-1:0] wr_data,
	output logic [acpe_pkg::DUR_W-1:0] model_rd,
	output logic [acpe_pkg::DUR_W-1:0] next_rd
);
	import acpe_pkg::*;

	logic [DUR_W-1:0] model_mem [MAX_PHASES];
	logic [DUR_W-1:0] next_mem [MAX_PHASES];

	always_ff @(posedge clk) begin
		if (ctl.load_we || ctl.copy_we) begin
			model_mem[wr_addr] <= wr_data;
		end
		if (ctl.load_we || ctl.next_we) begin
			next_mem[wr_addr] <= wr_data;
		end
		model_rd <= model_mem[rd_addr];
		next_rd <= next_mem[rd_addr];
	end
endmodule

// File: rtl/core/acpe_div.sv
// restoring divider giving the fractional quotient of num / den, num below den
module acpe_div #(
	parameter int W = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [W-1:0]                num,
	input  logic [W-2:0]                den,
	output logic                        done,
	output logic [acpe_pkg::FRAC_W-1:0] quot
);
	import acpe_pkg::*;

	localparam int CNT_W = $clog2(FRAC_W + 1);

	logic [W-1:0] rem_q;
	logic [W-1:0] den_q;
	logic [FRAC_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [W-1:0] rem_sh;
	logic [W-1:0] rem_sub;
	logic fits;

	always_comb begin
		rem_sh = {rem_q[W-2:0], 1'b0};
		fits = rem_sh >= den_q;
		rem_sub = rem_sh - den_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(FRAC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= {1'b0, den};
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub : rem_sh;
			quot_q <= {quot_q[FRAC_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// File: rtl/core/acpe_checker.sv
// port-level checks of the phase estimator, bound to the top level
`include "adaptive_cyclic_phase_estimator_assert.svh"

module acpe_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [acpe_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import acpe_pkg::*;

	// a held result keeps its payload
	`ACPE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// an accepted transaction leaves the block busy in the following cycle
	`ACPE_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// a backward timestamp reports no progress and no phase change
	`ACPE_ASSERT_IMP(a_terr_clean, m_tvalid && m_tdata[PROG_W+PHASE_W+1],
		m_tdata[PROG_W-1:0] == '0 && !m_tdata[PROG_W+PHASE_W])
	// progress never exceeds one
	`ACPE_ASSERT_IMP(a_prog_range, m_tvalid && m_tdata[FRAC_W], m_tdata[FRAC_W-1:0] == '0)
endmodule

bind adaptive_cyclic_phase_estimator acpe_checker u_acpe_checker (.*);
